// ===== design/fesq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fesq_pkg
// Types and constants shared by the flash erase / program sequencer.
// ----------------------------------------------------------------------------
package fesq_pkg;

  localparam logic [1:0] OP_ERASE  = 2'd0;
  localparam logic [1:0] OP_PROG   = 2'd1;
  localparam logic [1:0] OP_STATUS = 2'd2;

  localparam logic [3:0] A_NONE   = 4'd0;
  localparam logic [3:0] A_KEY    = 4'd1;
  localparam logic [3:0] A_COFF   = 4'd2;
  localparam logic [3:0] A_CRST   = 4'd3;
  localparam logic [3:0] A_CON    = 4'd4;
  localparam logic [3:0] A_SEL    = 4'd5;
  localparam logic [3:0] A_START  = 4'd6;
  localparam logic [3:0] A_CLRER  = 4'd7;
  localparam logic [3:0] A_PGEN   = 4'd8;
  localparam logic [3:0] A_WORD   = 4'd9;
  localparam logic [3:0] A_CLRERR = 4'd10;
  localparam logic [3:0] A_CLREOP = 4'd11;
  localparam logic [3:0] A_PGDIS  = 4'd12;
  localparam logic [3:0] A_LOCK   = 4'd13;
  localparam logic [3:0] A_DUMMY  = 4'd14;

  localparam logic [2:0] OC_RUN     = 3'd0;
  localparam logic [2:0] OC_OK      = 3'd1;
  localparam logic [2:0] OC_TIMEOUT = 3'd2;
  localparam logic [2:0] OC_SUSP    = 3'd3;
  localparam logic [2:0] OC_FLASH   = 3'd4;
  localparam logic [2:0] OC_MISALN  = 3'd5;
  localparam logic [2:0] OC_NOEOP   = 3'd6;

  localparam logic [1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_RETRIES = 2'd1;
  localparam logic [1:0] CFG_DUMMY   = 2'd2;

  localparam logic [31:0] KEY_A       = 32'h4567_0123;
  localparam logic [31:0] KEY_B       = 32'hCDEF_89AB;
  localparam logic [31:0] DUMMY_VALUE = 32'd12323;
  localparam logic [23:0] TIMEOUT_RST = 24'd1600000;
  localparam logic [2:0]  RETRIES_RST = 3'd3;
  localparam logic [31:0] DUMMY_RST   = 32'h0802_0000;

  localparam int MAX_ACTS = 6;

  typedef struct packed {
    logic [3:0]  act;
    logic [31:0] addr;
    logic [31:0] val;
  } fesq_act_t;

  typedef struct packed {
    fesq_act_t [MAX_ACTS-1:0] acts;
    logic [2:0]               n;
    logic [2:0]               outcome;
  } fesq_bundle_t;

  function automatic fesq_bundle_t add_act(fesq_bundle_t bi, logic [3:0] a,
                                           logic [31:0] ad, logic [31:0] v);
    fesq_bundle_t bo;
    bo = bi;
    bo.acts[bi.n] = '{act: a, addr: ad, val: v};
    bo.n = bi.n + 3'd1;
    return bo;
  endfunction

endpackage

// ===== design/fesq_cmd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fesq_cmd_if
// Command and status word channel.
// ----------------------------------------------------------------------------
interface fesq_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  first_page;
  logic [7:0]  page_count;
  logic [31:0] target_address;
  logic [63:0] program_data;
  logic [3:0]  bytes_valid;
  logic        busy_flag;
  logic        config_busy_flag;
  logic        suspend_flag;
  logic        end_of_op_flag;
  logic [7:0]  error_flags;
  logic        locked_flag;

  modport source (output valid, operation, first_page, page_count, target_address,
                  program_data, bytes_valid, busy_flag, config_busy_flag,
                  suspend_flag, end_of_op_flag, error_flags, locked_flag,
                  input ready);
  modport sink (input valid, operation, first_page, page_count, target_address,
                program_data, bytes_valid, busy_flag, config_busy_flag,
                suspend_flag, end_of_op_flag, error_flags, locked_flag,
                output ready);
endinterface

// ===== design/fesq_res_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fesq_res_if
// Register action word channel.
// ----------------------------------------------------------------------------
interface fesq_res_if;
  logic        valid;
  logic        ready;
  logic [3:0]  action;
  logic [31:0] action_address;
  logic [31:0] action_value;
  logic        last_action;
  logic [2:0]  outcome;

  modport source (output valid, action, action_address, action_value, last_action,
                  outcome, input ready);
  modport sink (input valid, action, action_address, action_value, last_action,
                outcome, output ready);
endinterface

// ===== design/fesq_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fesq_cfg_if
// Configuration register write channel.
// ----------------------------------------------------------------------------
interface fesq_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/fesq_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fesq_front
// Takes command / status words, steps the sequence and builds action bundles.
// ----------------------------------------------------------------------------
module fesq_front
  import fesq_pkg::*;
#(
  parameter int POLL_COUNTER_BITS = 24
) (
  input  logic         clk,
  input  logic         rst,
  fesq_cmd_if.sink     cmd,
  fesq_cfg_if.sink     cfg,
  input  logic         q_full,
  output logic         push,
  output fesq_bundle_t bundle
);

  localparam int P  = POLL_COUNTER_BITS;
  localparam int LW = (P > 24) ? P : 24;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_EWA  = 5'd1;
  localparam logic [4:0] S_EW1  = 5'd2;
  localparam logic [4:0] S_ELA  = 5'd3;
  localparam logic [4:0] S_ELB  = 5'd4;
  localparam logic [4:0] S_PWA  = 5'd5;
  localparam logic [4:0] S_PW1  = 5'd6;
  localparam logic [4:0] S_PW2  = 5'd7;
  localparam logic [4:0] S_PW3  = 5'd8;

  logic [23:0]  timeout_limit;
  logic [2:0]   workaround_retries;
  logic [31:0]  dummy_write_address;
  logic [4:0]   state, state_next;
  logic [P-1:0] poll_counter, poll_counter_next;
  logic [1:0]   wait_phase, wait_phase_next;
  logic [7:0]   pages_done, pages_done_next;
  logic [2:0]   retry_counter, retry_counter_next;
  logic [31:0]  sc0, sc0_next;
  logic [63:0]  sc1, sc1_next;

  logic [LW-1:0] tl_ext, cap_ext;
  logic [P-1:0]  lim;
  logic          accept;

  assign accept    = cmd.valid & cmd.ready;
  assign cmd.ready = ~q_full;
  assign cfg.ready = 1'b1;
  assign push      = accept;

  assign tl_ext  = LW'(timeout_limit);
  assign cap_ext = LW'({P{1'b1}});
  assign lim     = (tl_ext > cap_ext) ? {P{1'b1}} : tl_ext[P-1:0];

  always_comb begin
    fesq_bundle_t b;
    logic [2:0]   res;
    logic [1:0]   wres;
    logic         decided, again, wa_done, go_w1;
    logic [P-1:0] pc;
    logic [1:0]   ph;
    logic [2:0]   flags;
    logic [7:0]   errs, cnt, pdn;
    logic [3:0]   nvalid;
    logic [63:0]  data;

    b                  = '0;
    res                = OC_RUN;
    state_next         = state;
    poll_counter_next  = poll_counter;
    wait_phase_next    = wait_phase;
    pages_done_next    = pages_done;
    retry_counter_next = retry_counter;
    sc0_next           = sc0;
    sc1_next           = sc1;
    errs               = cmd.error_flags;
    cnt                = sc0[15:8];
    flags              = {cmd.suspend_flag, cmd.config_busy_flag, cmd.busy_flag};
    go_w1              = 1'b0;
    again              = 1'b0;
    wa_done            = 1'b0;
    pdn                = pages_done + 8'd1;
    nvalid             = (cmd.bytes_valid > 4'd8) ? 4'd8 : cmd.bytes_valid;
    data               = cmd.program_data;

    // busy wait: 0 waiting, 1 done, 2 timeout
    pc      = poll_counter;
    ph      = wait_phase;
    decided = 1'b0;
    wres    = 2'd0;
    if (lim == '0) begin
      wres    = 2'd2;
      decided = 1'b1;
    end else begin
      for (int k = 0; k < 3; k++) begin
        if (!decided && ph == 2'(k)) begin
          if (flags[k]) begin
            pc      = pc + 1'b1;
            wres    = (pc >= lim) ? 2'd2 : 2'd0;
            decided = 1'b1;
          end else begin
            ph = 2'(k + 1);
            pc = '0;
          end
        end
      end
    end
    if (!decided) begin
      ph   = 2'd0;
      pc   = '0;
      wres = 2'd1;
    end

    if (accept) begin
      if (state == S_IDLE) begin
        if (cmd.operation == OP_ERASE || cmd.operation == OP_PROG) begin
          pages_done_next    = '0;
          poll_counter_next  = '0;
          wait_phase_next    = '0;
          retry_counter_next = '0;
          if (cmd.operation == OP_ERASE) begin
            sc0_next   = {16'd0, cmd.page_count, cmd.first_page};
            sc1_next   = '0;
            state_next = S_EWA;
          end else begin
            for (int i = 0; i < 8; i++) begin
              if (4'(i) >= nvalid) data[8*i +: 8] = 8'hFF;
            end
            sc0_next   = cmd.target_address;
            sc1_next   = data;
            state_next = S_PWA;
          end
        end
      end else if (cmd.operation == OP_STATUS) begin
        if (state == S_EWA || state == S_PWA) begin
          again   = cmd.config_busy_flag && (retry_counter < workaround_retries);
          wa_done = 1'b0;
          if (errs != '0 && (retry_counter != '0 || again))
            b = add_act(b, A_CLRERR, '0, {24'd0, errs});
          if (again) begin
            b = add_act(b, A_DUMMY, dummy_write_address, DUMMY_VALUE);
            retry_counter_next = retry_counter + 3'd1;
          end else begin
            retry_counter_next = '0;
            wa_done            = 1'b1;
          end
          if (wa_done) begin
            if (state == S_EWA) begin
              go_w1 = 1'b1;
            end else begin
              b = add_act(b, A_COFF, '0, '0);
              b = add_act(b, A_CRST, '0, '0);
              if (sc0[2:0] != 3'd0) res = OC_MISALN;
              else go_w1 = 1'b1;
            end
          end
        end

        if (go_w1 || state == S_EW1 || state == S_PW1) begin
          poll_counter_next = pc;
          wait_phase_next   = ph;
          if (wres == 2'd2) begin
            res = OC_TIMEOUT;
          end else if (wres == 2'd1) begin
            if (cmd.suspend_flag) begin
              res = OC_SUSP;
            end else begin
              if (cmd.locked_flag) begin
                b = add_act(b, A_KEY, '0, KEY_A);
                b = add_act(b, A_KEY, '0, KEY_B);
              end
              if (state == S_PWA || state == S_PW1) begin
                state_next = S_PW2;
              end else begin
                b = add_act(b, A_COFF, '0, '0);
                if (cnt == '0) begin
                  b   = add_act(b, A_CON, '0, '0);
                  b   = add_act(b, A_LOCK, '0, '0);
                  res = OC_OK;
                end else begin
                  state_next = S_ELA;
                end
              end
            end
          end else begin
            state_next = go_w1 ? ((state == S_EWA) ? S_EW1 : S_PW1) : state;
          end
        end else if (state == S_ELA || state == S_ELB || state == S_PW2 ||
                     state == S_PW3) begin
          poll_counter_next = pc;
          wait_phase_next   = ph;
          if (wres == 2'd2) begin
            res = OC_TIMEOUT;
          end else if (wres == 2'd1) begin
            priority if (state == S_ELA) begin
              if (errs != '0) begin
                b   = add_act(b, A_CLRERR, '0, {24'd0, errs});
                res = OC_FLASH;
              end else begin
                b = add_act(b, A_SEL, '0, {24'd0, sc0[7:0] + pages_done});
                b = add_act(b, A_START, '0, '0);
                state_next = S_ELB;
              end
            end else if (state == S_ELB) begin
              b = add_act(b, A_CLRER, '0, '0);
              if (errs != '0) begin
                b   = add_act(b, A_CLRERR, '0, {24'd0, errs});
                res = OC_FLASH;
              end else begin
                pages_done_next = pdn;
                if (pdn == cnt) begin
                  b   = add_act(b, A_CON, '0, '0);
                  b   = add_act(b, A_LOCK, '0, '0);
                  res = OC_OK;
                end else begin
                  b = add_act(b, A_SEL, '0, {24'd0, sc0[7:0] + pdn});
                  b = add_act(b, A_START, '0, '0);
                end
              end
            end else if (state == S_PW2) begin
              if (errs != '0) begin
                b   = add_act(b, A_CLRERR, '0, {24'd0, errs});
                res = OC_FLASH;
              end else begin
                b = add_act(b, A_PGEN, '0, '0);
                b = add_act(b, A_WORD, sc0, sc1[31:0]);
                b = add_act(b, A_WORD, sc0 + 32'd4, sc1[63:32]);
                state_next = S_PW3;
              end
            end else begin
              b   = add_act(b, A_CLREOP, '0, '0);
              b   = add_act(b, A_PGDIS, '0, '0);
              b   = add_act(b, A_CON, '0, '0);
              b   = add_act(b, A_LOCK, '0, '0);
              res = cmd.end_of_op_flag ? OC_OK : OC_NOEOP;
            end
          end
        end else if (!(state == S_EWA || state == S_PWA)) begin
          state_next = S_IDLE;
        end

        if (res != OC_RUN) begin
          state_next         = S_IDLE;
          poll_counter_next  = '0;
          wait_phase_next    = '0;
          retry_counter_next = '0;
        end
      end
    end
    if (b.n == 3'd0) b = add_act(b, A_NONE, '0, '0);
    b.outcome = res;
    bundle    = b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= S_IDLE;
      poll_counter        <= '0;
      wait_phase          <= '0;
      pages_done          <= '0;
      retry_counter       <= '0;
      timeout_limit       <= TIMEOUT_RST;
      workaround_retries  <= RETRIES_RST;
      dummy_write_address <= DUMMY_RST;
    end else begin
      state         <= state_next;
      poll_counter  <= poll_counter_next;
      wait_phase    <= wait_phase_next;
      pages_done    <= pages_done_next;
      retry_counter <= retry_counter_next;
      if (cfg.valid) begin
        unique case (cfg.index)
          CFG_TIMEOUT: timeout_limit       <= cfg.data[23:0];
          CFG_RETRIES: workaround_retries  <= cfg.data[2:0];
          CFG_DUMMY:   dummy_write_address <= cfg.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    sc0 <= sc0_next;
    sc1 <= sc1_next;
  end

endmodule

// ===== design/fesq_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fesq_queue
// Two-entry bundle queue between front and back.
// ----------------------------------------------------------------------------
module fesq_queue
  import fesq_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  fesq_bundle_t wr_bundle,
  input  logic         pop,
  output fesq_bundle_t rd_bundle,
  output logic         full,
  output logic         empty
);

  fesq_bundle_t mem [2];
  logic         wr_ptr, rd_ptr;
  logic [1:0]   count;

  assign full      = count == 2'd2;
  assign empty     = count == 2'd0;
  assign rd_bundle = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_bundle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count out of range");
  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
      (empty || full) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with count");
`endif

endmodule

// ===== design/fesq_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fesq_back
// Expands queued bundles into one action word per cycle into the output
// register while res is ready.
// ----------------------------------------------------------------------------
module fesq_back
  import fesq_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  fesq_bundle_t bundle,
  input  logic         empty,
  output logic         pop,
  fesq_res_if.source   res
);

  logic [2:0] idx;
  logic       load, last;
  fesq_act_t  cur;

  assign load = ~empty & (~res.valid | res.ready);
  assign last = (idx + 3'd1) == bundle.n;
  assign pop  = load & last;
  assign cur  = bundle.acts[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        res.valid <= 1'b1;
        idx       <= last ? 3'd0 : idx + 3'd1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res.action         <= cur.act;
      res.action_address <= cur.addr;
      res.action_value   <= cur.val;
      res.last_action    <= last;
      res.outcome        <= last ? bundle.outcome : OC_RUN;
    end
  end

endmodule

// ===== design/flash_erase_program_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_erase_program_sequencer
// Erase / program sequencer for an embedded flash controller.
// ----------------------------------------------------------------------------
// Usage:
//   cmd : command and status words (valid/ready). An erase or program word
//         starts a sequence while idle; status words, one per poll, step it.
//   res : register action words (valid/ready). Every accepted cmd word gives
//         one to six action words, the last marked by last_action and
//         carrying the outcome (0 while the sequence is still running).
//   cfg : register writes (index, data), always ready; write only while idle.
// Throughput: one cmd word per cycle while each gives a single action word
//   and res is ready; overall the block emits one action word per cycle
//   while res is ready, set by the output register of the back end.
// Path: the first action word of a cmd word is registered twice: its bundle is
//   written to the queue, then the word is loaded into the output register.
// Reset: sequence idle, counters cleared, registers at their defaults.
// Stall: a stalled res holds its word; the two-entry queue fills and cmd
//   ready drops once both entries hold bundles.
// ----------------------------------------------------------------------------
module flash_erase_program_sequencer
  import fesq_pkg::*;
#(
  parameter int POLL_COUNTER_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  fesq_cmd_if.sink    cmd,
  fesq_cfg_if.sink    cfg,
  fesq_res_if.source  res
);

  fesq_bundle_t fb, qb;
  logic         push, pop, q_full, q_empty;

  fesq_front #(.POLL_COUNTER_BITS(POLL_COUNTER_BITS)) u_front (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .cfg    (cfg),
    .q_full (q_full),
    .push   (push),
    .bundle (fb)
  );

  fesq_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_bundle (fb),
    .pop       (pop),
    .rd_bundle (qb),
    .full      (q_full),
    .empty     (q_empty)
  );

  fesq_back u_back (
    .clk    (clk),
    .rst    (rst),
    .bundle (qb),
    .empty  (q_empty),
    .pop    (pop),
    .res    (res)
  );

endmodule

// ===== verif/fesq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fesq_checker
// Watches the command, configuration and action channels of the flash
// erase / program sequencer. Every accepted command or status word is run
// through a cycle-free model of the sequence to predict its action words,
// which are then compared field by field with the words the block emits.
// ----------------------------------------------------------------------------
module fesq_checker
  import fesq_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  fesq_cmd_if   cmd,
  fesq_cfg_if   cfg,
  fesq_res_if   res,
  output int    fails,
  output int    pending
);

  typedef enum logic [3:0] {
    SQ_IDLE, SQ_EWA, SQ_EW1, SQ_ELA, SQ_ELB, SQ_PWA, SQ_PW1, SQ_PW2, SQ_PW3
  } seq_t;

  typedef struct {
    logic [3:0]  act;
    logic [31:0] addr;
    logic [31:0] val;
    logic        last;
    logic [2:0]  oc;
  } act_word_t;

  logic [23:0] tmo_lim;
  logic [2:0]  wa_retries;
  logic [31:0] dummy_addr;

  seq_t        seq;
  logic [23:0] poll_cnt;
  logic [1:0]  wphase;
  logic [7:0]  pages_done;
  logic [63:0] cmd_lo, cmd_hi;
  logic [2:0]  wa_tries;

  logic        s_busy, s_cfgb, s_susp, s_eop, s_lock;
  logic [7:0]  s_errs;

  act_word_t   item_acts[$];
  act_word_t   exp_acts[$];

  assign pending = exp_acts.size();

  function automatic void put(logic [3:0] a, logic [31:0] ad, logic [31:0] v);
    if (item_acts.size() < 12) item_acts.push_back('{a, ad, v, 1'b0, OC_RUN});
  endfunction

  function automatic void to_idle();
    seq = SQ_IDLE;
    poll_cnt = '0;
    wphase = '0;
    wa_tries = '0;
  endfunction

  // 0 waiting, 1 done, 2 timed out
  function automatic int poll_wait();
    logic b;
    if (tmo_lim == 0) return 2;
    while (wphase < 3) begin
      b = (wphase == 0) ? s_busy : (wphase == 1) ? s_cfgb : s_susp;
      if (b) begin
        poll_cnt = poll_cnt + 24'd1;
        if (poll_cnt >= tmo_lim) return 2;
        return 0;
      end
      wphase = wphase + 2'd1;
      poll_cnt = '0;
    end
    wphase = '0;
    poll_cnt = '0;
    return 1;
  endfunction

  function automatic bit workaround_done();
    logic again;
    again = s_cfgb && (wa_tries < wa_retries);
    if (s_errs != 0 && (wa_tries > 0 || again)) put(A_CLRERR, '0, {24'd0, s_errs});
    if (again) begin
      put(A_DUMMY, dummy_addr, DUMMY_VALUE);
      wa_tries = wa_tries + 3'd1;
      return 0;
    end
    wa_tries = '0;
    return 1;
  endfunction

  function automatic logic [2:0] close_ok();
    put(A_CON, '0, '0);
    put(A_LOCK, '0, '0);
    return OC_OK;
  endfunction

  function automatic void sel_start();
    put(A_SEL, '0, {24'd0, cmd_lo[7:0] + pages_done});
    put(A_START, '0, '0);
  endfunction

  function automatic logic [2:0] step_seq();
    logic [7:0]  count;
    logic [31:0] addr;
    int          w;
    count = cmd_lo[15:8];
    addr = cmd_lo[31:0];
    forever begin
      case (seq)
        SQ_EWA, SQ_PWA: begin
          if (!workaround_done()) return OC_RUN;
          if (seq == SQ_EWA) seq = SQ_EW1;
          else begin
            put(A_COFF, '0, '0);
            put(A_CRST, '0, '0);
            if (addr[2:0] != 0) return OC_MISALN;
            seq = SQ_PW1;
          end
        end
        SQ_EW1, SQ_PW1: begin
          w = poll_wait();
          if (w == 0) return OC_RUN;
          if (w == 2) return OC_TIMEOUT;
          if (s_susp) return OC_SUSP;
          if (s_lock) begin
            put(A_KEY, '0, KEY_A);
            put(A_KEY, '0, KEY_B);
          end
          if (seq == SQ_PW1) begin
            seq = SQ_PW2;
            return OC_RUN;
          end
          put(A_COFF, '0, '0);
          if (count == 0) return close_ok();
          seq = SQ_ELA;
          return OC_RUN;
        end
        SQ_ELA: begin
          w = poll_wait();
          if (w == 0) return OC_RUN;
          if (w == 2) return OC_TIMEOUT;
          if (s_errs != 0) begin
            put(A_CLRERR, '0, {24'd0, s_errs});
            return OC_FLASH;
          end
          sel_start();
          seq = SQ_ELB;
          return OC_RUN;
        end
        SQ_ELB: begin
          w = poll_wait();
          if (w == 0) return OC_RUN;
          if (w == 2) return OC_TIMEOUT;
          put(A_CLRER, '0, '0);
          if (s_errs != 0) begin
            put(A_CLRERR, '0, {24'd0, s_errs});
            return OC_FLASH;
          end
          pages_done = pages_done + 8'd1;
          if (pages_done == count) return close_ok();
          sel_start();
          return OC_RUN;
        end
        SQ_PW2: begin
          w = poll_wait();
          if (w == 0) return OC_RUN;
          if (w == 2) return OC_TIMEOUT;
          if (s_errs != 0) begin
            put(A_CLRERR, '0, {24'd0, s_errs});
            return OC_FLASH;
          end
          put(A_PGEN, '0, '0);
          put(A_WORD, addr, cmd_hi[31:0]);
          put(A_WORD, addr + 32'd4, cmd_hi[63:32]);
          seq = SQ_PW3;
          return OC_RUN;
        end
        SQ_PW3: begin
          w = poll_wait();
          if (w == 0) return OC_RUN;
          if (w == 2) return OC_TIMEOUT;
          put(A_CLREOP, '0, '0);
          put(A_PGDIS, '0, '0);
          put(A_CON, '0, '0);
          put(A_LOCK, '0, '0);
          return s_eop ? OC_OK : OC_NOEOP;
        end
        default: begin
          to_idle();
          return OC_RUN;
        end
      endcase
    end
  endfunction

  function automatic void predict_word();
    logic [2:0]  oc;
    logic [63:0] data;
    int          n;
    oc = OC_RUN;
    item_acts.delete();
    s_busy = cmd.busy_flag;
    s_cfgb = cmd.config_busy_flag;
    s_susp = cmd.suspend_flag;
    s_eop  = cmd.end_of_op_flag;
    s_lock = cmd.locked_flag;
    s_errs = cmd.error_flags;
    if (seq == SQ_IDLE) begin
      if (cmd.operation == OP_ERASE) begin
        cmd_lo = {48'd0, cmd.page_count, cmd.first_page};
        cmd_hi = '0;
        pages_done = '0;
        to_idle();
        seq = SQ_EWA;
      end else if (cmd.operation == OP_PROG) begin
        data = cmd.program_data;
        n = (cmd.bytes_valid > 8) ? 8 : cmd.bytes_valid;
        for (int i = n; i < 8; i++) data[8*i +: 8] = 8'hFF;
        cmd_lo = {32'd0, cmd.target_address};
        cmd_hi = data;
        pages_done = '0;
        to_idle();
        seq = SQ_PWA;
      end
    end else if (cmd.operation == OP_STATUS) begin
      oc = step_seq();
      if (oc != OC_RUN) to_idle();
    end
    if (item_acts.size() == 0) put(A_NONE, '0, '0);
    item_acts[item_acts.size()-1].last = 1'b1;
    item_acts[item_acts.size()-1].oc = oc;
    foreach (item_acts[i]) exp_acts.push_back(item_acts[i]);
  endfunction

  always @(posedge clk) begin
    act_word_t e;
    if (rst) begin
      tmo_lim = TIMEOUT_RST;
      wa_retries = RETRIES_RST;
      dummy_addr = DUMMY_RST;
      to_idle();
      pages_done = '0;
      cmd_lo = '0;
      cmd_hi = '0;
      exp_acts.delete();
      fails = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_TIMEOUT: tmo_lim = cfg.data[23:0];
          CFG_RETRIES: wa_retries = cfg.data[2:0];
          CFG_DUMMY:   dummy_addr = cfg.data;
          default: ;
        endcase
      end
      if (res.valid && res.ready) begin
        if (exp_acts.size() == 0) begin
          $error("action word with none expected: action %0d", res.action);
          fails++;
        end else begin
          e = exp_acts.pop_front();
          if (res.action !== e.act) begin
            $error("action: expected %0d, got %0d", e.act, res.action);
            fails++;
          end
          if (res.action_address !== e.addr) begin
            $error("action_address: expected %h, got %h", e.addr, res.action_address);
            fails++;
          end
          if (res.action_value !== e.val) begin
            $error("action_value: expected %h, got %h", e.val, res.action_value);
            fails++;
          end
          if (res.last_action !== e.last) begin
            $error("last_action: expected %0d, got %0d", e.last, res.last_action);
            fails++;
          end
          if (res.outcome !== e.oc) begin
            $error("outcome: expected %0d, got %0d", e.oc, res.outcome);
            fails++;
          end
        end
      end
      if (cmd.valid && cmd.ready) predict_word();
    end
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the flash erase / program sequencer: directed erase, program
// and status words, then mostly well-formed random sequences under several
// register settings and idling patterns; the checker gives the verdict data.
// ----------------------------------------------------------------------------
module tb;
  import fesq_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fails, pending;
  int   send_pct = 0, recv_pct = 0;
  bit   hold_go = 1'b0;
  int   hold_cnt = 0;
  bit   hold_done = 1'b0;

  fesq_cmd_if cmd_if ();
  fesq_cfg_if cfg_if ();
  fesq_res_if res_if ();

  flash_erase_program_sequencer i_dut (
    .clk (clk), .rst (rst), .cmd (cmd_if), .cfg (cfg_if), .res (res_if)
  );

  fesq_checker i_chk (
    .clk (clk), .rst (rst), .cmd (cmd_if), .cfg (cfg_if), .res (res_if),
    .fails (fails), .pending (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

  // receiver, with one long counted hold-off
  always @(negedge clk) begin
    if (hold_go && !hold_done && hold_cnt < 300) begin
      hold_cnt++;
      res_if.ready = 1'b0;
      if (hold_cnt == 300) hold_done = 1'b1;
    end else begin
      res_if.ready = ($urandom_range(99) >= recv_pct);
    end
  end

  task automatic put_word(logic [1:0] op, logic [7:0] fp, logic [7:0] pc,
                          logic [31:0] ad, logic [63:0] d, logic [3:0] bv,
                          logic [4:0] fl, logic [7:0] er);
    while ($urandom_range(99) < send_pct) begin
      cmd_if.valid = 1'b0;
      @(negedge clk);
    end
    cmd_if.valid = 1'b1;
    cmd_if.operation = op;
    cmd_if.first_page = fp;
    cmd_if.page_count = pc;
    cmd_if.target_address = ad;
    cmd_if.program_data = d;
    cmd_if.bytes_valid = bv;
    {cmd_if.busy_flag, cmd_if.config_busy_flag, cmd_if.suspend_flag,
     cmd_if.end_of_op_flag, cmd_if.locked_flag} = fl;
    cmd_if.error_flags = er;
    do @(posedge clk); while (!cmd_if.ready);
    @(negedge clk);
  endtask

  // flags: busy, config busy, suspend, eop, locked
  task automatic status(logic [4:0] fl, logic [7:0] er);
    put_word(OP_STATUS, 8'($urandom), 8'($urandom), $urandom, {$urandom, $urandom},
             4'($urandom), fl, er);
  endtask

  task automatic drain();
    cmd_if.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] d);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data = d;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic random_words(int count);
    int          r;
    logic [7:0]  pc;
    logic [31:0] ad;
    logic [3:0]  bv;
    logic [4:0]  fl;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 7) begin
        r = $urandom_range(99);
        pc = (r < 70) ? 8'($urandom_range(3)) : (r < 98) ? 8'($urandom_range(15, 4))
             : 8'($urandom_range(255, 200));
        put_word(OP_ERASE, 8'($urandom), pc, $urandom, {$urandom, $urandom},
                 4'($urandom), 5'($urandom), 8'($urandom));
      end else if (r < 14) begin
        ad = $urandom;
        if ($urandom_range(99) < 85) ad[2:0] = 3'd0;
        bv = ($urandom_range(99) < 90) ? 4'($urandom_range(8, 1))
             : 4'($urandom_range(15));
        put_word(OP_PROG, 8'($urandom), 8'($urandom), ad, {$urandom, $urandom}, bv,
                 5'($urandom), 8'($urandom));
      end else if (r < 16) begin
        put_word(2'($urandom_range(3)), 8'($urandom), 8'($urandom), $urandom,
                 {$urandom, $urandom}, 4'($urandom), 5'($urandom), 8'($urandom));
      end else begin
        fl[4] = ($urandom_range(99) < 30);
        fl[3] = ($urandom_range(99) < 20);
        fl[2] = ($urandom_range(99) < 4);
        fl[1] = ($urandom_range(99) < 85);
        fl[0] = 1'($urandom_range(1));
        status(fl, ($urandom_range(99) < 8) ? 8'($urandom_range(255, 1)) : 8'd0);
      end
    end
  endtask

  initial begin
    cmd_if.valid = 1'b0;
    cmd_if.operation = OP_STATUS;
    cmd_if.first_page = '0;
    cmd_if.page_count = '0;
    cmd_if.target_address = '0;
    cmd_if.program_data = '0;
    cmd_if.bytes_valid = '0;
    {cmd_if.busy_flag, cmd_if.config_busy_flag, cmd_if.suspend_flag,
     cmd_if.end_of_op_flag, cmd_if.locked_flag} = '0;
    cmd_if.error_flags = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_TIMEOUT;
    cfg_if.data = '0;
    res_if.ready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: idle status, erase of zero pages, wrap of page number
    status(5'b00010, 8'h00);
    put_word(OP_ERASE, 8'd0, 8'd0, '0, '0, 4'd1, '0, '0);
    status(5'b01011, 8'hFF);
    status(5'b01010, 8'h81);
    status(5'b00010, 8'h00);
    put_word(OP_ERASE, 8'd0, 8'd0, '0, '0, 4'd1, '0, '0);
    put_word(OP_ERASE, 8'hFF, 8'd2, '0, '0, 4'd1, '0, '0);
    status(5'b00010, 8'h00);
    status(5'b10000, 8'h00);
    status(5'b00000, 8'h00);
    status(5'b00001, 8'h00);
    status(5'b00110, 8'h00);
    status(5'b00010, 8'h00);
    // misaligned, then full fill with bytes valid zero, and bytes valid above eight
    put_word(OP_PROG, '0, '0, 32'hFFFF_FFFF, 64'h0, 4'd8, '0, '0);
    status(5'b00010, 8'h00);
    put_word(OP_PROG, '0, '0, 32'hFFFF_FFF8, 64'h0, 4'd0, '0, '0);
    status(5'b00010, 8'h00);
    status(5'b00100, 8'h00);
    put_word(OP_PROG, '0, '0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, '0, '0);
    status(5'b00010, 8'h00);
    status(5'b00010, 8'h00);
    status(5'b00000, 8'h00);
    put_word(2'd3, '0, '0, '0, '0, 4'd1, '0, '0);
    drain();

    cfg_write(CFG_TIMEOUT, 32'd1);
    cfg_write(CFG_RETRIES, 32'd0);
    cfg_write(CFG_DUMMY, 32'd0);
    send_pct = 8;
    recv_pct = 69;
    random_words(100);
    drain();

    cfg_write(CFG_TIMEOUT, 32'hFF_FFFF);
    cfg_write(CFG_RETRIES, 32'd7);
    cfg_write(CFG_DUMMY, 32'hFFFF_FFFF);
    send_pct = 69;
    recv_pct = 8;
    random_words(20);
    send_pct = 0;
    hold_go = 1'b1;
    random_words(90);
    drain();

    cfg_write(CFG_TIMEOUT, $urandom_range(6, 2));
    cfg_write(CFG_RETRIES, $urandom_range(7));
    cfg_write(CFG_DUMMY, $urandom);
    recv_pct = 0;
    random_words(110);
    drain();

    cfg_write(CFG_TIMEOUT, $urandom_range(60, 5));
    cfg_write(CFG_RETRIES, $urandom_range(3, 1));
    random_words(110);
    drain();

    if (fails == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/fesq_pkg.sv
design/fesq_cmd_if.sv
design/fesq_res_if.sv
design/fesq_cfg_if.sv
design/fesq_front.sv
design/fesq_queue.sv
design/fesq_back.sv
design/flash_erase_program_sequencer.sv
verif/fesq_checker.sv
verif/tb.sv
